[design/clp_pkg.sv]
// Shared types, constants and arithmetic helpers for the band column profile block.
// No dependencies; every other file of the block except clp_queue imports this package.
`timescale 1ns / 1ps

package clp_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AOI_HEIGHT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 2'd3;

    localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
    localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RST = 12'd480;
    localparam logic [CFG_DATA_W-1:0] AOI_HEIGHT_RST   = 12'd100;
    localparam logic                  MODE_RST         = 1'b0;

    // Datapath widths
    localparam int PIX_W      = 8;
    localparam int SUM_W      = 19;
    localparam int DIV_W      = 12;
    localparam int COL_OUT_W  = 11;
    localparam int DIV_STAGES = SUM_W;

    localparam logic [SUM_W-1:0] SUM_MAX = 19'h7FFFF;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } sums_t;

    // Classification of an in-band pixel, handed from the front to the back.
    typedef struct packed {
        logic first;   // first row of the band: the sum restarts
        logic emit;    // last row of the band: a profile entry is produced
        logic last;    // last column of the row
    } item_flags_t;

    // Partial remainder and the dividend/quotient shift word of one channel.
    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [SUM_W-1:0] qd;
    } div_state_t;

    function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [PIX_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W + 1 - PIX_W){1'b0}}, b};
        sat_add = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    // One restoring division step: brings down the next dividend bit and
    // shifts one quotient bit in at the bottom of the same word.
    function automatic div_state_t div_step(div_state_t cur, logic [DIV_W-1:0] d);
        logic [DIV_W:0] trial;
        logic [DIV_W:0] diff;
        div_state_t     nxt;
        trial = {cur.rem, cur.qd[SUM_W-1]};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d})
        begin
            nxt.rem = diff[DIV_W-1:0];
            nxt.qd  = {cur.qd[SUM_W-2:0], 1'b1};
        end
        else
        begin
            nxt.rem = trial[DIV_W-1:0];
            nxt.qd  = {cur.qd[SUM_W-2:0], 1'b0};
        end
        div_step = nxt;
    endfunction

endpackage

[design/clp_pixel_if.sv]
// Pixel request channel: valid/ready handshake with one RGB pixel and a frame mark.
// Depends on clp_pkg for the component width.
`timescale 1ns / 1ps

interface clp_pixel_if import clp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             frame_start;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;

    modport source (output valid, frame_start, red, green, blue, input ready);
    modport sink   (input valid, frame_start, red, green, blue, output ready);
endinterface

[design/clp_profile_if.sv]
// Profile request channel: valid/ready handshake with one column entry of the profile.
// Depends on clp_pkg for the column and value widths.
`timescale 1ns / 1ps

interface clp_profile_if import clp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [COL_OUT_W-1:0] column;
    logic [SUM_W-1:0]     red_value;
    logic [SUM_W-1:0]     green_value;
    logic [SUM_W-1:0]     blue_value;
    logic                 last;

    modport source (output valid, column, red_value, green_value, blue_value, last,
                    input ready);
    modport sink   (input valid, column, red_value, green_value, blue_value, last,
                    output ready);
endinterface

[design/clp_front.sv]
// Front end: configuration registers, raster counters and band classification.
// Depends on clp_pkg and clp_pixel_if; feeds in-band pixels to the queue.
`timescale 1ns / 1ps

module clp_front import clp_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    clp_pixel_if.sink                     pixel,
    output logic                          q_valid,
    input  logic                          q_ready,
    output logic [$clog2(MAX_WIDTH)-1:0]  q_col,
    output item_flags_t                   q_flags,
    output logic [DIV_W-1:0]              q_divisor,
    output rgb_t                          q_pix
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WCW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
    localparam int WRW = (RW + 1 > CFG_DATA_W) ? RW + 1 : CFG_DATA_W;

    logic [CFG_DATA_W-1:0] image_width_reg;
    logic [CFG_DATA_W-1:0] image_height_reg;
    logic [CFG_DATA_W-1:0] aoi_height_reg;
    logic                  mode_reg;

    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;

    logic [RW-1:0]    band_lo_reg, band_lo_next;
    logic [RW-1:0]    band_hi_reg, band_hi_next;
    logic [DIV_W-1:0] divisor_reg, divisor_next;

    logic             s1_valid_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [RW-1:0]    s1_row_reg;
    logic             s1_last_reg;
    rgb_t             s1_pix_reg;

    logic [WCW-1:0]   width_ext, width_eff, width_m1;
    logic [WRW-1:0]   height_ext, height_eff, height_m1;
    logic [WRW-1:0]   band_ext, band_eff, band_lo_ext, band_hi_ext;
    logic [CW-1:0]    col_last;
    logic [RW-1:0]    row_last;
    logic [CW-1:0]    cur_col;
    logic [RW-1:0]    cur_row;
    logic             at_row_end;
    logic             accept;
    logic             in_band;
    logic             s1_go;

    // Effective frame size; zero acts as one, oversize is capped.
    always_comb
    begin
        width_ext = WCW'(image_width_reg);
        if (image_width_reg == '0)
            width_eff = WCW'(1);
        else if (width_ext > WCW'(MAX_WIDTH))
            width_eff = WCW'(MAX_WIDTH);
        else
            width_eff = width_ext;
        width_m1 = width_eff - WCW'(1);
        col_last = width_m1[CW-1:0];

        height_ext = WRW'(image_height_reg);
        if (image_height_reg == '0)
            height_eff = WRW'(1);
        else if (height_ext > WRW'(MAX_HEIGHT))
            height_eff = WRW'(MAX_HEIGHT);
        else
            height_eff = height_ext;
        height_m1 = height_eff - WRW'(1);
        row_last  = height_m1[RW-1:0];
    end

    // Band limits change only with configuration, so they are retimed here and
    // used one stage after the counters.
    always_comb
    begin
        band_ext = (aoi_height_reg == '0) ? WRW'(1) : WRW'(aoi_height_reg);
        band_eff = (band_ext > height_eff) ? height_eff : band_ext;
        band_lo_ext  = (height_eff - band_eff) >> 1;
        band_hi_ext  = band_lo_ext + band_eff - WRW'(1);
        band_lo_next = band_lo_ext[RW-1:0];
        band_hi_next = band_hi_ext[RW-1:0];
        divisor_next = mode_reg ? band_eff[DIV_W-1:0] : DIV_W'(1);
    end

    assign accept     = pixel.valid && pixel.ready;
    assign cur_col    = pixel.frame_start ? '0 : col_reg;
    assign cur_row    = pixel.frame_start ? '0 : row_reg;
    assign at_row_end = (cur_col >= col_last);

    always_comb
    begin
        if (at_row_end)
        begin
            col_next = '0;
            row_next = (cur_row >= row_last) ? '0 : cur_row + RW'(1);
        end
        else
        begin
            col_next = cur_col + CW'(1);
            row_next = cur_row;
        end
    end

    assign in_band = (s1_row_reg >= band_lo_reg) && (s1_row_reg <= band_hi_reg);
    assign s1_go   = !s1_valid_reg || !in_band || q_ready;

    assign pixel.ready = s1_go;

    assign q_valid         = s1_valid_reg && in_band;
    assign q_col           = s1_col_reg;
    assign q_flags.first   = (s1_row_reg == band_lo_reg);
    assign q_flags.emit    = (s1_row_reg == band_hi_reg);
    assign q_flags.last    = s1_last_reg;
    assign q_divisor       = divisor_reg;
    assign q_pix           = s1_pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
            aoi_height_reg   <= AOI_HEIGHT_RST;
            mode_reg         <= MODE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                CFG_AOI_HEIGHT:   aoi_height_reg   <= cfg_data;
                CFG_MODE:         mode_reg         <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_go)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        band_lo_reg <= band_lo_next;
        band_hi_reg <= band_hi_next;
        divisor_reg <= divisor_next;
        if (accept)
        begin
            s1_col_reg       <= cur_col;
            s1_row_reg       <= cur_row;
            s1_last_reg      <= at_row_end;
            s1_pix_reg.red   <= pixel.red;
            s1_pix_reg.green <= pixel.green;
            s1_pix_reg.blue  <= pixel.blue;
        end
    end

endmodule

[design/clp_queue.sv]
// Short register FIFO that decouples the classifying front from the accumulating back.
// Generic in width and depth; it has no dependencies.
`timescale 1ns / 1ps

module clp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != NW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + NW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[design/clp_accum.sv]
// Back end, first half: read-modify-write of the per-column RGB sums in a memory.
// Depends on clp_pkg; takes items from clp_queue and feeds clp_div.
`timescale 1ns / 1ps

module clp_accum import clp_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic [$clog2(MAX_WIDTH)-1:0]  q_col,
    input  item_flags_t                   q_flags,
    input  logic [DIV_W-1:0]              q_divisor,
    input  rgb_t                          q_pix,
    output logic                          acc_valid,
    output logic [$clog2(MAX_WIDTH)-1:0]  acc_col,
    output logic                          acc_last,
    output logic [DIV_W-1:0]              acc_divisor,
    output sums_t                         acc_sums
);

    localparam int CW = $clog2(MAX_WIDTH);

    sums_t            sum_mem [MAX_WIDTH];
    sums_t            rd_sums_reg;

    logic             b1_valid_reg;
    logic [CW-1:0]    b1_col_reg;
    item_flags_t      b1_flags_reg;
    logic [DIV_W-1:0] b1_divisor_reg;
    rgb_t             b1_pix_reg;

    // The read for the next item happens at the same edge as this item's write,
    // so a back-to-back hit on one column takes the value just written.
    logic             fwd_valid_reg;
    logic [CW-1:0]    fwd_col_reg;
    sums_t            fwd_sums_reg;

    sums_t            base_sums;
    sums_t            new_sums;

    assign q_ready = adv;

    always_comb
    begin
        base_sums = (fwd_valid_reg && fwd_col_reg == b1_col_reg) ? fwd_sums_reg : rd_sums_reg;
        if (b1_flags_reg.first)
        begin
            new_sums.red   = SUM_W'(b1_pix_reg.red);
            new_sums.green = SUM_W'(b1_pix_reg.green);
            new_sums.blue  = SUM_W'(b1_pix_reg.blue);
        end
        else
        begin
            new_sums.red   = sat_add(base_sums.red, b1_pix_reg.red);
            new_sums.green = sat_add(base_sums.green, b1_pix_reg.green);
            new_sums.blue  = sat_add(base_sums.blue, b1_pix_reg.blue);
        end
    end

    assign acc_valid   = b1_valid_reg && b1_flags_reg.emit;
    assign acc_col     = b1_col_reg;
    assign acc_last    = b1_flags_reg.last;
    assign acc_divisor = b1_divisor_reg;
    assign acc_sums    = new_sums;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg  <= q_valid;
            fwd_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (b1_valid_reg)
                sum_mem[b1_col_reg] <= new_sums;
            rd_sums_reg    <= sum_mem[q_col];
            b1_col_reg     <= q_col;
            b1_flags_reg   <= q_flags;
            b1_divisor_reg <= q_divisor;
            b1_pix_reg     <= q_pix;
            fwd_col_reg    <= b1_col_reg;
            fwd_sums_reg   <= new_sums;
        end
    end

endmodule

[design/clp_div.sv]
// Back end, second half: pipelined restoring divider, one quotient bit per stage,
// whose last stage is the output register. Depends on clp_pkg and clp_profile_if.
`timescale 1ns / 1ps

module clp_div import clp_pkg::*; #(
    parameter int COL_W = 11
) (
    input  logic              clk,
    input  logic              rst_n,
    output logic              adv,
    input  logic              acc_valid,
    input  logic [COL_W-1:0]  acc_col,
    input  logic              acc_last,
    input  logic [DIV_W-1:0]  acc_divisor,
    input  sums_t             acc_sums,
    clp_profile_if.source     profile
);

    localparam int CXW = (COL_W > COL_OUT_W) ? COL_W : COL_OUT_W;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             last;
        logic [DIV_W-1:0] divisor;
        div_state_t       red;
        div_state_t       green;
        div_state_t       blue;
    } stage_t;

    stage_t                  stage_reg  [DIV_STAGES];
    stage_t                  stage_next [DIV_STAGES];
    logic [DIV_STAGES-1:0]   valid_reg;
    logic [DIV_STAGES-1:0]   valid_next;
    stage_t                  entry;
    logic [CXW-1:0]          col_wide;

    // A sum entry carries divisor one, so its quotient is the sum itself.
    always_comb
    begin
        entry.col       = acc_col;
        entry.last      = acc_last;
        entry.divisor   = acc_divisor;
        entry.red.rem   = '0;
        entry.red.qd    = acc_sums.red;
        entry.green.rem = '0;
        entry.green.qd  = acc_sums.green;
        entry.blue.rem  = '0;
        entry.blue.qd   = acc_sums.blue;
    end

    always_comb
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                stage_next[s] = entry;
                valid_next[s] = acc_valid;
            end
            else
            begin
                stage_next[s] = stage_reg[s-1];
                valid_next[s] = valid_reg[s-1];
            end
            stage_next[s].red   = div_step(stage_next[s].red, stage_next[s].divisor);
            stage_next[s].green = div_step(stage_next[s].green, stage_next[s].divisor);
            stage_next[s].blue  = div_step(stage_next[s].blue, stage_next[s].divisor);
        end
    end

    assign adv = !valid_reg[DIV_STAGES-1] || profile.ready;

    assign col_wide            = CXW'(stage_reg[DIV_STAGES-1].col);
    assign profile.valid       = valid_reg[DIV_STAGES-1];
    assign profile.column      = col_wide[COL_OUT_W-1:0];
    assign profile.red_value   = stage_reg[DIV_STAGES-1].red.qd;
    assign profile.green_value = stage_reg[DIV_STAGES-1].green.qd;
    assign profile.blue_value  = stage_reg[DIV_STAGES-1].blue.qd;
    assign profile.last        = stage_reg[DIV_STAGES-1].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
                stage_reg[s] <= stage_next[s];
        end
    end

endmodule

[design/band_column_profile_core.sv]
// Top level of the band column profile: front, queue, accumulator and divider.
// Depends on clp_pkg, clp_pixel_if, clp_profile_if and the clp_* modules.
//
//   Channel   Direction  Carries                                   Handshake
//   pixel     in         frame_start, red, green, blue             valid/ready
//   profile   out        column, red/green/blue_value, last        valid/ready
//   cfg       in         cfg_index, cfg_data                       cfg_write, no wait
//
// One pixel per clock is taken as long as the profile side accepts its entries.
// The entry of a band-last-row pixel passes, after the pixel is accepted,
// the front register, one queue slot, the sum memory read and update stage,
// and 19 divider stages, the last of which is the output register.
// Reset clears counters, queue and pipeline valids; the sum memory is not
// cleared, the band's first row of each frame overwrites it.
// A held profile entry stalls the whole back end; the four-entry queue absorbs
// that, and pixels outside the band are never queued.
`timescale 1ns / 1ps

module band_column_profile_core import clp_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    clp_pixel_if.sink             pixel,
    clp_profile_if.source         profile
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int FLG_W = $bits(item_flags_t);
    localparam int PIX_B = $bits(rgb_t);
    localparam int QW    = CW + FLG_W + DIV_W + PIX_B;

    logic             fq_valid, fq_ready;
    logic [CW-1:0]    fq_col;
    item_flags_t      fq_flags;
    logic [DIV_W-1:0] fq_divisor;
    rgb_t             fq_pix;

    logic [QW-1:0]    push_data, pop_data;

    logic             bq_valid, bq_ready;
    logic [CW-1:0]    bq_col;
    item_flags_t      bq_flags;
    logic [DIV_W-1:0] bq_divisor;
    rgb_t             bq_pix;

    logic             adv;
    logic             acc_valid;
    logic [CW-1:0]    acc_col;
    logic             acc_last;
    logic [DIV_W-1:0] acc_divisor;
    sums_t            acc_sums;

    clp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_col     (fq_col),
        .q_flags   (fq_flags),
        .q_divisor (fq_divisor),
        .q_pix     (fq_pix)
    );

    assign push_data = {fq_col, fq_flags, fq_divisor, fq_pix};

    clp_queue #(
        .WIDTH (QW),
        .DEPTH (4)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (push_data),
        .pop_valid  (bq_valid),
        .pop_ready  (bq_ready),
        .pop_data   (pop_data)
    );

    assign {bq_col, bq_flags, bq_divisor, bq_pix} = pop_data;

    clp_accum #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .q_valid     (bq_valid),
        .q_ready     (bq_ready),
        .q_col       (bq_col),
        .q_flags     (bq_flags),
        .q_divisor   (bq_divisor),
        .q_pix       (bq_pix),
        .acc_valid   (acc_valid),
        .acc_col     (acc_col),
        .acc_last    (acc_last),
        .acc_divisor (acc_divisor),
        .acc_sums    (acc_sums)
    );

    clp_div #(
        .COL_W (CW)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .acc_valid   (acc_valid),
        .acc_col     (acc_col),
        .acc_last    (acc_last),
        .acc_divisor (acc_divisor),
        .acc_sums    (acc_sums),
        .profile     (profile)
    );

endmodule
